// ===== src/stream_find_replace_macros.svh =====
// assertion macros for the find-and-replace block
// they expect clk and rst_n in the scope of the use
`ifndef STREAM_FIND_REPLACE_MACROS_SVH
`define STREAM_FIND_REPLACE_MACROS_SVH
`ifndef SYNTH
`define SFR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfr assertion failed");
`define SFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfr assertion failed");
`else
`define SFR_ASSERT_IMPL(label, ante, cons)
`define SFR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/sfr_pkg.sv =====
`default_nettype none
package sfr_pkg;

  localparam int MAX_PATTERN_DEF     = 8;
  localparam int MAX_REPLACEMENT_DEF = 8;
  localparam int BYTE_W              = 8;
  localparam int CFG_DATA_W          = 64;
  localparam int CFG_IDX_W           = 2;
  localparam int REG_LEN_W           = 4;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              byte_present;
    logic              line_end;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_present;
    logic              out_line_end;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_write_t;

  // byte idx of a 64-bit register, zero past the eighth byte
  function automatic logic [BYTE_W-1:0] reg_byte(input logic [CFG_DATA_W-1:0] r,
                                                 input int idx);
    logic [CFG_DATA_W-1:0] s;
    s = r >> (BYTE_W * idx);
    return s[BYTE_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/sfr_stream_if.sv =====
`default_nettype none
interface sfr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/stream_find_replace.sv =====
// output: the first result of an accepted item is on out_ch in the cycle after acceptance
// throughput: one item per cycle while each item gives at most one result and out_ch is ready; an item that
//   gives k results holds the result register until all k have gone out, one transaction each,
//   and the input waits until the last of them is being taken
// reset: synchronous, active low; registers return to their reset values, window empty
`default_nettype none
module stream_find_replace #(
  parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  sfr_stream_if.sink   in_ch,
  sfr_stream_if.source out_ch,
  sfr_stream_if.sink   cfg_ch
);
`include "stream_find_replace_macros.svh"

  // one item can produce a full replacement or a full window flush
  localparam int MAX_RESULTS = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int RW = $clog2(MAX_REPLACEMENT + 1);
  localparam int BW = $clog2(MAX_RESULTS + 1);
  localparam int BYW = sfr_pkg::BYTE_W;

  // configuration registers
  logic [sfr_pkg::CFG_DATA_W-1:0] pat_bytes_r;
  logic [sfr_pkg::REG_LEN_W-1:0]  pat_len_r;
  logic [sfr_pkg::CFG_DATA_W-1:0] rep_bytes_r;
  logic [sfr_pkg::REG_LEN_W-1:0]  rep_len_r;

  // pending window of text bytes, oldest in entry 0
  logic [BYW-1:0] win_r   [MAX_PATTERN];
  logic [BYW-1:0] win_nxt [MAX_PATTERN];
  logic [CW-1:0]  win_cnt_r, win_cnt_nxt;

  // result register: a batch of results that drains one transaction per cycle while out_ch is ready
  logic [BYW-1:0] bat_byte_r   [MAX_RESULTS];
  logic [BYW-1:0] bat_byte_nxt [MAX_RESULTS];
  logic [BW-1:0]  bat_cnt_r, bat_cnt_nxt;
  logic           bat_pres_r, bat_pres_nxt;
  logic           bat_end_r, bat_end_nxt;

  // per-item datapath
  logic             in_fire, out_fire, cfg_fire;
  logic [CW-1:0]    plen;
  logic [RW-1:0]    rlen;
  logic             present_ok;
  logic [CW-1:0]    cnt1;
  logic             do_cmp;
  logic             pat_eq;
  logic             match;
  logic [BYW-1:0]   ww [MAX_RESULTS];
  logic [BW-1:0]    n_new;
  sfr_pkg::in_item_t  in_item;
  sfr_pkg::out_item_t out_item;
  sfr_pkg::cfg_reg_t  cfg_sel;

  assign in_item = in_ch.data;
  assign cfg_sel = sfr_pkg::cfg_reg_t'(cfg_ch.data.reg_index);

  // take a new item when the batch is empty or its last result leaves now
  assign in_ch.ready = (bat_cnt_r == '0) || ((bat_cnt_r == BW'(1)) && out_ch.ready);
  assign cfg_ch.ready = 1'b1;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;

  assign out_ch.valid          = (bat_cnt_r != '0);
  assign out_item.out_byte     = bat_byte_r[0];
  assign out_item.out_present  = bat_pres_r;
  // the line end flag rides on the last result of the batch only
  assign out_item.out_line_end = bat_end_r && (bat_cnt_r == BW'(1));
  assign out_ch.data           = out_item;

  // effective lengths: zero pattern length counts as one, both saturate
  always_comb begin
    if (pat_len_r == '0) begin
      plen = CW'(1);
    end else if (int'(pat_len_r) > MAX_PATTERN) begin
      plen = CW'(MAX_PATTERN);
    end else begin
      plen = CW'(pat_len_r);
    end
    if (int'(rep_len_r) > MAX_REPLACEMENT) begin
      rlen = RW'(MAX_REPLACEMENT);
    end else begin
      rlen = RW'(rep_len_r);
    end
  end

  // window with the incoming byte appended, then the compare against the pattern
  always_comb begin
    present_ok = in_item.byte_present && (int'(win_cnt_r) < MAX_PATTERN);
    for (int i = 0; i < MAX_RESULTS; i++) begin
      ww[i] = '0;
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      ww[i] = (present_ok && (win_cnt_r == CW'(i))) ? in_item.text_byte : win_r[i];
    end
    cnt1   = win_cnt_r + CW'(present_ok);
    do_cmp = present_ok && (cnt1 >= plen);
    pat_eq = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((CW'(i) < plen) && (ww[i] != sfr_pkg::reg_byte(pat_bytes_r, i))) begin
        pat_eq = 1'b0;
      end
    end
    match = do_cmp && pat_eq;
  end

  // next batch and window
  always_comb begin
    // result count of the incoming item
    if (match) begin
      n_new = BW'(rlen);
    end else if (in_item.line_end) begin
      // a mismatch emits the oldest byte and the flush the rest, so the whole window goes out
      n_new = BW'(cnt1);
    end else if (do_cmp) begin
      n_new = BW'(1);
    end else begin
      n_new = '0;
    end

    bat_cnt_nxt  = bat_cnt_r;
    bat_pres_nxt = bat_pres_r;
    bat_end_nxt  = bat_end_r;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      bat_byte_nxt[i] = bat_byte_r[i];
    end

    if (in_fire) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        bat_byte_nxt[i] = match ? sfr_pkg::reg_byte(rep_bytes_r, i) : ww[i];
      end
      bat_end_nxt  = in_item.line_end;
      bat_pres_nxt = 1'b1;
      bat_cnt_nxt  = n_new;
      // empty line end: one bare marker
      if (in_item.line_end && (n_new == '0)) begin
        bat_byte_nxt[0] = '0;
        bat_pres_nxt    = 1'b0;
        bat_cnt_nxt     = BW'(1);
      end
    end else if (out_fire) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        bat_byte_nxt[i] = bat_byte_r[i + 1];
      end
      bat_cnt_nxt = bat_cnt_r - BW'(1);
    end

    win_cnt_nxt = win_cnt_r;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_nxt[i] = win_r[i];
    end
    if (cfg_fire && (cfg_sel == sfr_pkg::REG_PATTERN_LENGTH)) begin
      // a new pattern length drops whatever is pending
      win_cnt_nxt = '0;
    end else if (in_fire) begin
      if (match || in_item.line_end) begin
        win_cnt_nxt = '0;
      end else if (do_cmp) begin
        // oldest byte went out, slide the window down
        for (int i = 0; i < MAX_PATTERN - 1; i++) begin
          win_nxt[i] = ww[i + 1];
        end
        win_cnt_nxt = cnt1 - CW'(1);
      end else begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
          win_nxt[i] = ww[i];
        end
        win_cnt_nxt = cnt1;
      end
    end
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r <= '0;
      pat_len_r   <= sfr_pkg::REG_LEN_W'(1);
      rep_bytes_r <= '0;
      rep_len_r   <= '0;
      win_cnt_r   <= '0;
      bat_cnt_r   <= '0;
      bat_pres_r  <= 1'b0;
      bat_end_r   <= 1'b0;
    end else begin
      win_cnt_r  <= win_cnt_nxt;
      bat_cnt_r  <= bat_cnt_nxt;
      bat_pres_r <= bat_pres_nxt;
      bat_end_r  <= bat_end_nxt;
      if (cfg_fire) begin
        unique case (cfg_sel)
          sfr_pkg::REG_PATTERN_BYTES: begin
            pat_bytes_r <= cfg_ch.data.wdata;
          end
          sfr_pkg::REG_PATTERN_LENGTH: begin
            pat_len_r <= cfg_ch.data.wdata[sfr_pkg::REG_LEN_W-1:0];
          end
          sfr_pkg::REG_REPLACEMENT_BYTES: begin
            rep_bytes_r <= cfg_ch.data.wdata;
          end
          sfr_pkg::REG_REPLACEMENT_LENGTH: begin
            rep_len_r <= cfg_ch.data.wdata[sfr_pkg::REG_LEN_W-1:0];
          end
          default: begin
            pat_len_r <= pat_len_r;
          end
        endcase
      end
    end
  end

  // payload storage, no reset needed
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_r[i] <= win_nxt[i];
    end
    for (int i = 0; i < MAX_RESULTS; i++) begin
      bat_byte_r[i] <= bat_byte_nxt[i];
    end
  end

  // an item is only taken when no result would be overwritten
  `SFR_ASSERT_IMPL(a_accept_no_overwrite, in_fire, (bat_cnt_r == '0) || ((bat_cnt_r == BW'(1)) && out_fire))
  // the window never holds a full pattern between items
  `SFR_ASSERT_IMPL(a_window_below_len, 1'b1, win_cnt_r < plen)
  // writing the pattern length empties the window
  `SFR_ASSERT_NEXT(a_len_write_clears, cfg_fire && (cfg_sel == sfr_pkg::REG_PATTERN_LENGTH), win_cnt_r == '0)
  // when the last result of a line leaves, nothing of that line is pending
  `SFR_ASSERT_IMPL(a_line_end_flushed, out_fire && out_item.out_line_end, win_cnt_r == '0)

endmodule
`default_nettype wire

// ===== verif/tb_stream_find_replace.sv =====
`timescale 1ns / 100ps

import sfr_pkg::*;

// predicts the rewritten line byte by byte and checks the block's results in order
class line_rewriter;
  logic [CFG_DATA_W-1:0] pattern;
  logic [CFG_DATA_W-1:0] replacement;
  logic [REG_LEN_W-1:0]  pat_len_reg;
  logic [REG_LEN_W-1:0]  rep_len_reg;
  logic [BYTE_W-1:0]     window [MAX_PATTERN_DEF];
  int unsigned           held;
  out_item_t             rewritten_bytes [$];
  int unsigned           fail_count;

  function new();
    pattern     = '0;
    replacement = '0;
    pat_len_reg = REG_LEN_W'(1);
    rep_len_reg = '0;
    foreach (window[i]) window[i] = '0;
    held       = 0;
    fail_count = 0;
  endfunction

  function void write_reg(cfg_write_t w);
    case (cfg_reg_t'(w.reg_index))
      REG_PATTERN_BYTES: pattern = w.wdata;
      REG_PATTERN_LENGTH: begin
        pat_len_reg = w.wdata[REG_LEN_W-1:0];
        held = 0;
      end
      REG_REPLACEMENT_BYTES: replacement = w.wdata;
      REG_REPLACEMENT_LENGTH: rep_len_reg = w.wdata[REG_LEN_W-1:0];
      default: ;
    endcase
  endfunction

  function void take_text_item(in_item_t it);
    int unsigned span;
    int unsigned rlen;
    int unsigned made;
    bit          hit;
    out_item_t   o;
    span = (pat_len_reg == 0) ? 1 :
           (pat_len_reg > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : pat_len_reg;
    rlen = (rep_len_reg > MAX_REPLACEMENT_DEF) ? MAX_REPLACEMENT_DEF : rep_len_reg;
    made = 0;
    if (it.byte_present && held < MAX_PATTERN_DEF) begin
      window[held] = it.text_byte;
      held++;
      if (held >= span) begin
        hit = 1'b1;
        for (int i = 0; i < span; i++)
          if (window[i] !== pattern[BYTE_W*i +: BYTE_W]) hit = 1'b0;
        if (hit) begin
          for (int i = 0; i < rlen; i++) begin
            o = {replacement[BYTE_W*i +: BYTE_W], 1'b1, 1'b0};
            rewritten_bytes.push_back(o);
          end
          made += rlen;
          held = 0;
        end else begin
          o = {window[0], 1'b1, 1'b0};
          rewritten_bytes.push_back(o);
          made++;
          for (int i = 1; i < held; i++) window[i-1] = window[i];
          held--;
        end
      end
    end
    if (it.line_end) begin
      for (int i = 0; i < held; i++) begin
        o = {window[i], 1'b1, 1'b0};
        rewritten_bytes.push_back(o);
      end
      made += held;
      held = 0;
      if (made == 0) begin
        o = {8'h00, 1'b0, 1'b1};
        rewritten_bytes.push_back(o);
      end else begin
        o = rewritten_bytes.pop_back();
        o.out_line_end = 1'b1;
        rewritten_bytes.push_back(o);
      end
    end
  endfunction

  function void check_out_item(out_item_t got);
    out_item_t want;
    if (rewritten_bytes.size() == 0) begin
      $error("unexpected result: out_byte %0h out_present %0b out_line_end %0b",
             got.out_byte, got.out_present, got.out_line_end);
      fail_count++;
      return;
    end
    want = rewritten_bytes.pop_front();
    if (got.out_byte !== want.out_byte) begin
      $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
      fail_count++;
    end
    if (got.out_present !== want.out_present) begin
      $error("out_present: expected %0b, actual %0b", want.out_present, got.out_present);
      fail_count++;
    end
    if (got.out_line_end !== want.out_line_end) begin
      $error("out_line_end: expected %0b, actual %0b", want.out_line_end, got.out_line_end);
      fail_count++;
    end
  endfunction

  function int unsigned pending();
    return rewritten_bytes.size();
  endfunction
endclass

module tb_stream_find_replace;

  // cycles without any transaction before the run is declared hung
  localparam int STALL_LIMIT   = 2000;
  // long receiver hold-off so the block fills and back-pressures the sender
  localparam int HOLD_OFF      = 150;
  localparam int PHASE_ITEMS   = 52;
  localparam int NUM_PHASES    = 6;
  // settle time after the last expected result
  localparam int SETTLE_CYCLES = 4;

  logic clk;
  logic rst_n;

  sfr_stream_if #(.payload_t(in_item_t))   in_ch ();
  sfr_stream_if #(.payload_t(out_item_t))  out_ch ();
  sfr_stream_if #(.payload_t(cfg_write_t)) cfg_ch ();

  stream_find_replace dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  line_rewriter rewrite = new();

  // idle percentages for sender and receiver, changed per phase
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          hold_request;
  int unsigned quiet_cycles;

  // what the line generator knows about the current pattern
  logic [CFG_DATA_W-1:0] cur_pattern;
  int unsigned           pat_len_eff;
  logic [BYTE_W-1:0]     alphabet [3];

  // per-phase lengths: the extremes, zero and saturating values among them
  int unsigned plen_tbl [NUM_PHASES] = '{3, 8, 1, 15, 2, 0};
  int unsigned rlen_tbl [NUM_PHASES] = '{5, 0, 8, 15, 1, 2};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // everything driven known from time zero
  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    hold_request = 1'b0;
    tx_idle_pct  = 22;
    rx_idle_pct  = 87;
  end

  // receiver: random ready, with one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
        hold_request = 1'b0;
      end
      out_ch.ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // monitors: every transaction is seen at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) rewrite.write_reg(cfg_ch.data);
      if (in_ch.valid && in_ch.ready) rewrite.take_text_item(in_ch.data);
      if (out_ch.valid && out_ch.ready) rewrite.check_out_item(out_ch.data);
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one item, valid stays high until the transaction happens
  task automatic send_item(input logic [BYTE_W-1:0] b, input logic present,
                           input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      in_ch.data  = {8'($urandom), 1'($urandom), 1'($urandom)};
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.data  = {b, present, last};
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering and wait for every predicted result, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (rewrite.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.data  = {idx, value};
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // one line: pattern copies, near misses and random bytes, closed by a byte
  // or by a bare end marker, with the odd ignored item in between
  task automatic send_line(output int unsigned sent);
    logic [BYTE_W-1:0] text [$];
    int unsigned       want_len;
    int unsigned       pick;
    int unsigned       part;
    bit                close_on_byte;
    text     = {};
    sent     = 0;
    want_len = $urandom_range(0, 14);
    while (text.size() < want_len) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        for (int i = 0; i < pat_len_eff; i++)
          text.push_back(cur_pattern[BYTE_W*i +: BYTE_W]);
      end else if (pick < 40) begin
        // partial pattern followed by a likely mismatch
        part = $urandom_range(0, pat_len_eff - 1);
        for (int i = 0; i < part; i++) text.push_back(cur_pattern[BYTE_W*i +: BYTE_W]);
        text.push_back(alphabet[$urandom_range(0, 2)]);
      end else if (pick < 75) begin
        text.push_back(alphabet[$urandom_range(0, 2)]);
      end else begin
        text.push_back(8'($urandom_range(0, 255)));
      end
    end
    close_on_byte = (text.size() != 0) && ($urandom_range(1) == 1);
    foreach (text[i]) begin
      if ($urandom_range(99) < 4) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(text[i], 1'b1, close_on_byte && (i == text.size() - 1));
      sent++;
    end
    if (!close_on_byte) begin
      send_item(8'($urandom), 1'b0, 1'b1);
      sent++;
    end
  endtask

  initial begin
    int unsigned phase_count;
    int unsigned n;
    logic [CFG_DATA_W-1:0] rep;

    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset config: single zero byte pattern, empty replacement, so zeros vanish
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // empty line gives a bare end marker
    send_item(8'h5a, 1'b0, 1'b1);
    // no byte and no line end is ignored
    send_item(8'ha5, 1'b0, 1'b0);
    // deleted last byte leaves nothing to flush
    send_item(8'h00, 1'b1, 1'b1);
    wait_idle();

    // all-ones pattern at full length, full replacement
    write_reg(REG_PATTERN_BYTES, '1);
    write_reg(REG_PATTERN_LENGTH, 64'd8);
    write_reg(REG_REPLACEMENT_BYTES, 64'h0123_4567_89ab_cdef);
    write_reg(REG_REPLACEMENT_LENGTH, 64'd8);
    for (int i = 0; i < 8; i++) send_item(8'hff, 1'b1, i == 7);
    // short tail flushed at line end
    for (int i = 0; i < 3; i++) send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    wait_idle();

    // "ab" deleted: overlapping prefix then a match ending the line
    write_reg(REG_PATTERN_BYTES, 64'h6261);
    write_reg(REG_PATTERN_LENGTH, 64'd2);
    write_reg(REG_REPLACEMENT_LENGTH, 64'd0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b1);
    // length write mid-line drops the pending byte
    send_item(8'h61, 1'b1, 1'b0);
    wait_idle();
    write_reg(REG_PATTERN_LENGTH, 64'd2);
    send_item(8'h62, 1'b1, 1'b1);

    // random phases with a new setting each
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      if (p < 2) begin
        tx_idle_pct = 22;
        rx_idle_pct = 87;
      end else if (p < 4) begin
        tx_idle_pct = 87;
        rx_idle_pct = 22;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      foreach (alphabet[i]) alphabet[i] = 8'($urandom);
      for (int i = 0; i < MAX_PATTERN_DEF; i++)
        cur_pattern[BYTE_W*i +: BYTE_W] = alphabet[$urandom_range(0, 2)];
      pat_len_eff = (plen_tbl[p] == 0) ? 1 :
                    (plen_tbl[p] > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : plen_tbl[p];
      rep = {$urandom, $urandom};
      write_reg(REG_PATTERN_BYTES, cur_pattern);
      write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(plen_tbl[p]));
      write_reg(REG_REPLACEMENT_BYTES, rep);
      write_reg(REG_REPLACEMENT_LENGTH, CFG_DATA_W'(rlen_tbl[p]));
      // receiver stalls while the sender keeps pushing at full rate
      if (p == 4) hold_request = 1'b1;
      phase_count = 0;
      while (phase_count < PHASE_ITEMS) begin
        send_line(n);
        phase_count += n;
      end
    end

    wait_idle();
    repeat (10) @(negedge clk);
    if (rewrite.pending() != 0) begin
      $error("%0d expected results never arrived", rewrite.pending());
      rewrite.fail_count++;
    end
    if (rewrite.fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/sfr_pkg.sv
src/sfr_stream_if.sv
src/stream_find_replace.sv
verif/tb_stream_find_replace.sv
